/* design/asbs_pkg.sv */
// Shared types, constants and the sine table function of the additive sine bank synthesizer.
// No dependencies; the design modules and the testbench import this package.
`timescale 1ns / 1ps
`default_nettype none

package asbs_pkg;

    localparam int MAX_KEYS_DEFAULT        = 64;
    localparam int SINE_TABLE_BITS_DEFAULT = 10;

    localparam int AMP_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [AMP_W-1:0] AMP_ONE = 16'h8000;
    localparam logic [15:0]      SAMPLE_MAX = 16'd32767;

    localparam logic CMD_SET = 1'b0;
    localparam logic CMD_GEN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_KEYS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_RATIO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_COEF = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_GAIN    = 3'd4;

    localparam logic [6:0]  RST_NUM_KEYS    = 7'd64;
    localparam logic [31:0] RST_BASE_STEP   = 32'd26843546;
    localparam logic [31:0] RST_KEY_RATIO   = 32'd1090519040;
    localparam logic [15:0] RST_SMOOTH_COEF = 16'd131;
    localparam logic [15:0] RST_OUT_GAIN    = 16'd256;

    localparam logic [63:0] POLY_Q30 [6] = '{
        64'd1686629713, 64'd693598669, 64'd85569306, 64'd5026995, 64'd172272, 64'd3864
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_ABS,
        ST_SCALE,
        ST_OUT
    } asbs_state_t;

    typedef struct packed {
        logic clear;
        logic term_valid;
        logic take_abs;
        logic scale;
        logic load;
    } mix_ctl_t;

    typedef struct packed {
        logic busy;
        logic out_free;
    } mix_sts_t;

    // One table entry: a quarter wave from an odd polynomial in Q2.30, mirrored by quadrant.
    function automatic logic signed [15:0] sine_entry(input int unsigned idx,
                                                      input int unsigned tb);
        logic [63:0] quad;
        logic [63:0] r;
        logic [63:0] frac;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        int unsigned qb;
        logic signed [15:0] v;
        qb   = tb - 2;
        quad = 64'((idx >> qb) & 3);
        r    = 64'(idx) & ((64'd1 << qb) - 64'd1);
        frac = quad[0] ? ((64'd1 << qb) - r) : r;
        x    = frac << (30 - qb);
        x2   = (x * x) >> 30;
        p    = POLY_Q30[5];
        for (int j = 4; j >= 0; j--)
        begin
            p = POLY_Q30[j] - ((p * x2) >> 30);
        end
        p = (((p * x) >> 30) + 64'd16384) >> 15;
        if (p > 64'd32767)
        begin
            p = 64'd32767;
        end
        v = 16'(p);
        return quad[1] ? -v : v;
    endfunction

endpackage

`default_nettype wire

/* design/asbs_in_if.sv */
// Request channel of the additive sine bank synthesizer: valid, ready and one command.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface asbs_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [5:0]  key_index;
    logic [15:0] amplitude_value;

    modport source (output valid, output command, output key_index, output amplitude_value,
                    input ready);
    modport sink (input valid, input command, input key_index, input amplitude_value,
                  output ready);
endinterface

`default_nettype wire

/* design/asbs_out_if.sv */
// Sample channel of the additive sine bank synthesizer: valid, ready and one output sample.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface asbs_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               saturated;

    modport source (output valid, output sample, output saturated, input ready);
    modport sink (input valid, input sample, input saturated, output ready);
endinterface

`default_nettype wire

/* design/asbs_cfg_if.sv */
// Configuration write channel of the additive sine bank synthesizer: register index and data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface asbs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/additive_sine_bank_synth_unit.sv */
// Additive sine bank synthesizer top level: configuration registers, request sequencer,
// key walk with phase and amplitude smoothing. Uses asbs_pkg, the three channel interfaces,
// asbs_amp_store, asbs_sine_rom and asbs_mixer.
//
// A request on req either sets one key's target amplitude (command 0) or asks for one sample
// (command 1). A set request gives no response. A generate request walks keys 0 to
// keys_eff-1 (num_keys, capped at MAX_KEYS) through the amplitude memories, one key per cycle,
// then drains a three-stage key pipeline, takes the magnitude, scales by the gain and loads
// the sample into the output register as the sequencer returns to idle, where the next
// request can be taken. The key walk is bounded by the single read port of each memory.
// A finished sample waits in the output register while new requests are taken; if the
// receiver on rsp stalls, the next generate request holds in its last step until the
// register is free. cfg is always ready; it is to be written between requests, which the
// block itself does not enforce. Reset clears the sample position, loads the default
// register values and marks both amplitude memories as all zero; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module additive_sine_bank_synth_unit #(
    parameter int MAX_KEYS        = asbs_pkg::MAX_KEYS_DEFAULT,
    parameter int SINE_TABLE_BITS = asbs_pkg::SINE_TABLE_BITS_DEFAULT
) (
    input  wire         clk,
    input  wire         rst_n,
    asbs_in_if.sink     req,
    asbs_out_if.source  rsp,
    asbs_cfg_if.sink    cfg
);
    import asbs_pkg::*;

    localparam int AW   = $clog2(MAX_KEYS);
    localparam int KC_W = $clog2(MAX_KEYS + 1);

    asbs_state_t state_reg;
    asbs_state_t state_next;

    logic [6:0]  num_keys_reg;
    logic [31:0] base_step_reg;
    logic [31:0] key_ratio_reg;
    logic [15:0] smooth_coef_reg;
    logic [15:0] out_gain_reg;

    logic [31:0]   pos_reg;
    logic [KC_W-1:0] key_cnt_reg;
    logic [31:0]   step_reg;

    logic                       p1_valid_reg;
    logic [AW-1:0]              p1_key_reg;
    logic [SINE_TABLE_BITS-1:0] phase_idx_reg;
    logic                       p2_valid_reg;
    logic [AW-1:0]              p2_key_reg;
    logic [AMP_W-1:0]           sm_reg;

    logic            accept;
    logic            is_gen;
    logic            key_in_range;
    logic [KC_W-1:0] keys_eff;
    logic            last_key;
    logic            issue;
    logic [31:0]     phase_low;
    logic [63:0]     step_prod;
    logic [AMP_W-1:0] amp_clamped;
    logic [AMP_W-1:0] tgt_q;
    logic [AMP_W-1:0] sm_q;
    logic signed [16:0] amp_diff;
    logic signed [33:0] smooth_prod;
    logic signed [33:0] smooth_sum;
    logic [AMP_W-1:0] sm_next;
    logic signed [15:0] rom_q;
    mix_ctl_t        mix_ctl;
    mix_sts_t        mix_sts;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_keys_reg    <= RST_NUM_KEYS;
            base_step_reg   <= RST_BASE_STEP;
            key_ratio_reg   <= RST_KEY_RATIO;
            smooth_coef_reg <= RST_SMOOTH_COEF;
            out_gain_reg    <= RST_OUT_GAIN;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_NUM_KEYS:    num_keys_reg    <= cfg.data[6:0];
                CFG_BASE_STEP:   base_step_reg   <= cfg.data;
                CFG_KEY_RATIO:   key_ratio_reg   <= cfg.data;
                CFG_SMOOTH_COEF: smooth_coef_reg <= cfg.data[15:0];
                CFG_OUT_GAIN:    out_gain_reg    <= cfg.data[15:0];
                default:         ;
            endcase
        end
    end

    assign keys_eff = (32'(num_keys_reg) > 32'(MAX_KEYS)) ? KC_W'(MAX_KEYS)
                                                          : KC_W'(num_keys_reg);
    assign accept       = req.valid && req.ready;
    assign is_gen       = req.command == CMD_GEN;
    assign key_in_range = 32'(req.key_index) < 32'(MAX_KEYS);
    assign amp_clamped  = (req.amplitude_value > AMP_ONE) ? AMP_ONE : req.amplitude_value;
    assign last_key     = (key_cnt_reg + KC_W'(1)) == keys_eff;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_gen)
                begin
                    state_next = (keys_eff == '0) ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_key)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!p1_valid_reg && !p2_valid_reg && !mix_sts.busy)
                begin
                    state_next = ST_ABS;
                end
            end
            ST_ABS:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_OUT;
            ST_OUT:
            begin
                if (mix_sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req.ready          = 1'b0;
        issue              = 1'b0;
        mix_ctl.clear      = 1'b0;
        mix_ctl.take_abs   = 1'b0;
        mix_ctl.scale      = 1'b0;
        mix_ctl.load       = 1'b0;
        mix_ctl.term_valid = p2_valid_reg;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready     = 1'b1;
                mix_ctl.clear = req.valid && is_gen;
            end
            ST_RUN:   issue            = 1'b1;
            ST_DRAIN: ;
            ST_ABS:   mix_ctl.take_abs = 1'b1;
            ST_SCALE: mix_ctl.scale    = 1'b1;
            ST_OUT:   mix_ctl.load     = mix_sts.out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            key_cnt_reg  <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
            if (accept)
            begin
                key_cnt_reg <= '0;
            end
            else if (issue)
            begin
                key_cnt_reg <= key_cnt_reg + KC_W'(1);
            end
            if (mix_ctl.load)
            begin
                pos_reg <= pos_reg + 32'd1;
            end
        end
    end

    assign phase_low = pos_reg * step_reg;
    assign step_prod = 64'(step_reg) * 64'(key_ratio_reg);

    assign amp_diff    = $signed({1'b0, tgt_q}) - $signed({1'b0, sm_q});
    assign smooth_prod = 34'(amp_diff) * 34'($signed({1'b0, smooth_coef_reg}));
    assign smooth_sum  = $signed({2'b00, sm_q, 16'h0000}) + smooth_prod + 34'sd32768;
    assign sm_next     = smooth_sum[31:16];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            step_reg <= base_step_reg;
        end
        else if (issue)
        begin
            step_reg <= step_prod[61:30];
        end
        if (issue)
        begin
            p1_key_reg    <= key_cnt_reg[AW-1:0];
            phase_idx_reg <= phase_low[31 -: SINE_TABLE_BITS];
        end
        if (p1_valid_reg)
        begin
            p2_key_reg <= p1_key_reg;
            sm_reg     <= sm_next;
        end
    end

    asbs_amp_store #(
        .MAX_KEYS (MAX_KEYS)
    ) u_amp_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .tgt_we    (accept && !is_gen && key_in_range),
        .tgt_waddr (AW'(req.key_index)),
        .tgt_wdata (amp_clamped),
        .sm_we     (p2_valid_reg),
        .sm_waddr  (p2_key_reg),
        .sm_wdata  (sm_reg),
        .rd_en     (issue),
        .rd_addr   (key_cnt_reg[AW-1:0]),
        .tgt_q     (tgt_q),
        .sm_q      (sm_q)
    );

    asbs_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_rom (
        .clk  (clk),
        .addr (phase_idx_reg),
        .q    (rom_q)
    );

    asbs_mixer #(
        .MAX_KEYS (MAX_KEYS)
    ) u_mixer (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mix_ctl),
        .sine  (rom_q),
        .amp   (sm_reg),
        .gain  (out_gain_reg),
        .sts   (mix_sts),
        .rsp   (rsp)
    );

`ifndef ASSERT_OFF
    a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (key_cnt_reg < keys_eff))
        else $error("key walk past the active key count");
    a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !req.ready)
        else $error("request taken during a generate");
    a_pos_advance: assert property (@(posedge clk) disable iff (!rst_n)
        mix_ctl.load |=> (pos_reg == $past(pos_reg) + 32'd1))
        else $error("sample position did not advance with the sample");
    a_pipe_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ABS) |-> (!p1_valid_reg && !p2_valid_reg && !mix_sts.busy))
        else $error("scaling started before the key pipeline drained");
`endif

endmodule

`default_nettype wire

/* design/asbs_amp_store.sv */
// Target and smoothed amplitude memories, one synchronous read port each.
// Entries never written since reset read as zero through per-entry valid bits. Uses asbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asbs_amp_store #(
    parameter int MAX_KEYS = 64
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         tgt_we,
    input  wire [$clog2(MAX_KEYS)-1:0]  tgt_waddr,
    input  wire [asbs_pkg::AMP_W-1:0]   tgt_wdata,
    input  wire                         sm_we,
    input  wire [$clog2(MAX_KEYS)-1:0]  sm_waddr,
    input  wire [asbs_pkg::AMP_W-1:0]   sm_wdata,
    input  wire                         rd_en,
    input  wire [$clog2(MAX_KEYS)-1:0]  rd_addr,
    output logic [asbs_pkg::AMP_W-1:0]  tgt_q,
    output logic [asbs_pkg::AMP_W-1:0]  sm_q
);
    import asbs_pkg::*;

    logic [AMP_W-1:0]    tgt_mem [MAX_KEYS];
    logic [AMP_W-1:0]    sm_mem  [MAX_KEYS];
    logic [MAX_KEYS-1:0] tgt_vld_reg;
    logic [MAX_KEYS-1:0] sm_vld_reg;
    logic [AMP_W-1:0]    tgt_q_reg;
    logic [AMP_W-1:0]    sm_q_reg;
    logic                tgt_hit_reg;
    logic                sm_hit_reg;

    always_ff @(posedge clk)
    begin
        if (tgt_we)
        begin
            tgt_mem[tgt_waddr] <= tgt_wdata;
        end
        if (sm_we)
        begin
            sm_mem[sm_waddr] <= sm_wdata;
        end
        if (rd_en)
        begin
            tgt_q_reg <= tgt_mem[rd_addr];
            sm_q_reg  <= sm_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_vld_reg <= '0;
            sm_vld_reg  <= '0;
            tgt_hit_reg <= 1'b0;
            sm_hit_reg  <= 1'b0;
        end
        else
        begin
            if (tgt_we)
            begin
                tgt_vld_reg[tgt_waddr] <= 1'b1;
            end
            if (sm_we)
            begin
                sm_vld_reg[sm_waddr] <= 1'b1;
            end
            if (rd_en)
            begin
                tgt_hit_reg <= tgt_vld_reg[rd_addr];
                sm_hit_reg  <= sm_vld_reg[rd_addr];
            end
        end
    end

    assign tgt_q = tgt_hit_reg ? tgt_q_reg : '0;
    assign sm_q  = sm_hit_reg ? sm_q_reg : '0;

`ifndef ASSERT_OFF
    a_no_sm_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        (sm_we && rd_en) |-> (sm_waddr != rd_addr))
        else $error("smoothed write-back hits the entry being read");
    a_no_tgt_during_read: assert property (@(posedge clk) disable iff (!rst_n)
        !(tgt_we && rd_en))
        else $error("target write during a key walk");
    a_tgt_valid_set: assert property (@(posedge clk) disable iff (!rst_n)
        tgt_we |=> tgt_vld_reg[$past(tgt_waddr)])
        else $error("target valid bit not set after write");
`endif

endmodule

`default_nettype wire

/* design/asbs_sine_rom.sv */
// Full-wave sine table in Q1.15 with a registered read, built from the package polynomial.
// Uses asbs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module asbs_sine_rom #(
    parameter int SINE_TABLE_BITS = 10
) (
    input  wire                        clk,
    input  wire [SINE_TABLE_BITS-1:0]  addr,
    output logic signed [15:0]         q
);
    import asbs_pkg::*;

    localparam int TABLE_SIZE = 1 << SINE_TABLE_BITS;

    logic signed [15:0] rom_table [TABLE_SIZE];
    logic signed [15:0] q_reg;

    for (genvar i = 0; i < TABLE_SIZE; i++)
    begin : g_rom
        localparam logic signed [15:0] ENTRY = sine_entry(i, SINE_TABLE_BITS);
        assign rom_table[i] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= rom_table[addr];
    end

    assign q = q_reg;

endmodule

`default_nettype wire

/* design/asbs_mixer.sv */
// Weights each sine by its amplitude, accumulates, scales by the gain, saturates and holds
// the finished sample in the output register. Uses asbs_pkg and asbs_out_if.
`timescale 1ns / 1ps
`default_nettype none

module asbs_mixer #(
    parameter int MAX_KEYS = 64
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  asbs_pkg::mix_ctl_t         ctl,
    input  wire signed [15:0]          sine,
    input  wire [asbs_pkg::AMP_W-1:0]  amp,
    input  wire [15:0]                 gain,
    output asbs_pkg::mix_sts_t         sts,
    asbs_out_if.source                 rsp
);
    import asbs_pkg::*;

    localparam int ACC_W = 32 + $clog2(MAX_KEYS);
    localparam int SW    = ACC_W + 16;
    localparam int QW    = SW - 23;

    logic signed [31:0]    prod_reg;
    logic                  prod_valid_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0]      mag_reg;
    logic                  neg_reg;
    logic [QW-1:0]         q_reg;
    logic                  out_valid_reg;
    logic signed [15:0]    sample_reg;
    logic                  sat_reg;

    logic signed [31:0]    prod_next;
    logic [SW-1:0]         scaled_next;
    logic                  sat_next;
    logic [15:0]           clamp_mag;
    logic signed [15:0]    sample_next;

    assign prod_next   = 32'(sine) * 32'($signed({1'b0, amp}));
    assign scaled_next = SW'(mag_reg) * SW'(gain) + SW'(64'd1 << 22);
    assign sat_next    = q_reg > QW'(SAMPLE_MAX);
    assign clamp_mag   = sat_next ? SAMPLE_MAX : q_reg[15:0];
    assign sample_next = neg_reg ? -$signed(clamp_mag) : $signed(clamp_mag);

    always_ff @(posedge clk)
    begin
        if (ctl.term_valid)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.take_abs)
        begin
            neg_reg <= acc_reg[ACC_W-1];
            mag_reg <= acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        end
        if (ctl.scale)
        begin
            q_reg <= scaled_next[SW-1:23];
        end
        if (ctl.load)
        begin
            sample_reg <= sample_next;
            sat_reg    <= sat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= ctl.term_valid;
            if (ctl.clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_valid_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            if (ctl.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.busy     = prod_valid_reg;
    assign sts.out_free = !out_valid_reg || rsp.ready;

    assign rsp.valid     = out_valid_reg;
    assign rsp.sample    = sample_reg;
    assign rsp.saturated = sat_reg;

`ifndef ASSERT_OFF
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |-> (!out_valid_reg || rsp.ready))
        else $error("sample loaded over one not yet taken");
    a_no_add_on_clear: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |-> !prod_valid_reg)
        else $error("accumulator cleared while a term is pending");
    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.sample != 16'sh8000))
        else $error("sample outside the saturated range");
`endif

endmodule

`default_nettype wire

/* verif/additive_sine_bank_synth_unit_tb.sv */
// Self-checking testbench for additive_sine_bank_synth_unit: directed and random requests,
// register settings, random sender bursts and receiver stalls, with a bit-exact sample predictor.
// Depends on asbs_pkg, the three channel interfaces and the top level of the block.
`timescale 1ns / 1ps

module additive_sine_bank_synth_unit_tb;
    import asbs_pkg::*;

    localparam int BANK_KEYS     = MAX_KEYS_DEFAULT;
    localparam int TABLE_BITS    = SINE_TABLE_BITS_DEFAULT;
    localparam int TABLE_SIZE    = 1 << TABLE_BITS;
    localparam int QUARTER_BITS  = TABLE_BITS - 2;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 80;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 192;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               saturated;
    } synth_sample_t;

    class synth_scoreboard;
        logic [6:0]         num_keys;
        logic [31:0]        base_step;
        logic [31:0]        key_ratio;
        logic [15:0]        smooth_coef;
        logic [15:0]        out_gain;
        logic [31:0]        position;
        logic [15:0]        smoothed [BANK_KEYS];
        logic [15:0]        target [BANK_KEYS];
        logic signed [15:0] sine_lut [TABLE_SIZE];
        synth_sample_t      pending [$];
        int                 failures;
        int                 samples_checked;
        int                 clamped_seen;

        function new();
            logic [63:0] quad;
            logic [63:0] r;
            logic [63:0] frac;
            logic signed [15:0] v;
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                quad = 64'((i >> QUARTER_BITS) & 3);
                r    = 64'(i) & ((64'd1 << QUARTER_BITS) - 64'd1);
                frac = quad[0] ? ((64'd1 << QUARTER_BITS) - r) : r;
                v    = 16'(quarter_wave(frac << (30 - QUARTER_BITS)));
                sine_lut[i] = quad[1] ? -v : v;
            end
            num_keys    = RST_NUM_KEYS;
            base_step   = RST_BASE_STEP;
            key_ratio   = RST_KEY_RATIO;
            smooth_coef = RST_SMOOTH_COEF;
            out_gain    = RST_OUT_GAIN;
            position    = '0;
            for (int k = 0; k < BANK_KEYS; k++)
            begin
                smoothed[k] = '0;
                target[k]   = '0;
            end
            failures        = 0;
            samples_checked = 0;
            clamped_seen    = 0;
        endfunction

        // Quarter wave of sin(x * pi/2), x in Q2.30, result in Q1.15 limited to 32767.
        function logic [63:0] quarter_wave(logic [63:0] x);
            logic [63:0] x2;
            logic [63:0] acc;
            x2  = (x * x) >> 30;
            acc = POLY_Q30[5];
            for (int j = 4; j >= 0; j--)
            begin
                acc = POLY_Q30[j] - ((acc * x2) >> 30);
            end
            acc = (((acc * x) >> 30) + 64'd16384) >> 15;
            if (acc > 64'd32767)
            begin
                acc = 64'd32767;
            end
            return acc;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
            case (idx)
                CFG_NUM_KEYS:    num_keys    = value[6:0];
                CFG_BASE_STEP:   base_step   = value;
                CFG_KEY_RATIO:   key_ratio   = value;
                CFG_SMOOTH_COEF: smooth_coef = value[15:0];
                CFG_OUT_GAIN:    out_gain    = value[15:0];
                default: ;
            endcase
        endfunction

        function void note_request(logic cmd, logic [5:0] key, logic [15:0] amp);
            int unsigned   active;
            logic [31:0]   step;
            logic [31:0]   phase;
            logic [63:0]   t;
            logic [63:0]   s;
            logic [63:0]   c;
            logic [63:0]   prod;
            longint        acc;
            logic [63:0]   mag;
            logic [63:0]   q;
            logic          neg;
            synth_sample_t want;
            if (cmd == CMD_SET)
            begin
                if (amp > AMP_ONE)
                begin
                    amp = AMP_ONE;
                end
                if (int'(key) < BANK_KEYS)
                begin
                    target[key] = amp;
                end
                return;
            end
            active = (num_keys > BANK_KEYS) ? BANK_KEYS : num_keys;
            step   = base_step;
            acc    = 0;
            c      = 64'(smooth_coef);
            for (int k = 0; k < active; k++)
            begin
                t = 64'(target[k]);
                s = 64'(smoothed[k]);
                s = (t * c + s * (64'd65536 - c) + 64'd32768) >> 16;
                smoothed[k] = s[15:0];
                phase = position * step;
                acc += longint'(sine_lut[phase >> (32 - TABLE_BITS)]) * longint'(s[15:0]);
                prod = 64'(step) * 64'(key_ratio);
                step = prod[61:30];
            end
            neg = acc < 0;
            mag = neg ? 64'(-acc) : 64'(acc);
            q   = (mag * 64'(out_gain) + 64'd4194304) >> 23;
            want.saturated = q > 64'd32767;
            if (want.saturated)
            begin
                q = 64'd32767;
            end
            want.sample = neg ? -16'(q) : 16'(q);
            pending.push_back(want);
            position = position + 32'd1;
        endfunction

        task report_mismatch(string what, int got, int wanted);
            $display("mismatch in %s of sample %0d: got %0d, expected %0d",
                     what, samples_checked, got, wanted);
            failures++;
        endtask

        task check_sample(logic signed [15:0] got_sample, logic got_sat);
            synth_sample_t want;
            if (pending.size() == 0)
            begin
                report_mismatch("presence (no request waiting)", int'(got_sample), 0);
                return;
            end
            want = pending.pop_front();
            if (got_sample !== want.sample)
            begin
                report_mismatch("sample", int'(got_sample), int'(want.sample));
            end
            if (got_sat !== want.saturated)
            begin
                report_mismatch("saturated", int'(got_sat), int'(want.saturated));
            end
            if (want.saturated)
            begin
                clamped_seen++;
            end
            samples_checked++;
        endtask
    endclass

    logic clk;
    logic rst_n;

    asbs_in_if  req_ch ();
    asbs_out_if rsp_ch ();
    asbs_cfg_if cfg_ch ();

    additive_sine_bank_synth_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    synth_scoreboard sb;
    int burst_left;
    int set_count;
    int gen_count;
    int settings_count;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    initial
    begin
        #8000000;
        $display("CHECK FAILED");
        $finish;
    end

    task push_request(logic cmd, logic [5:0] key, logic [15:0] amp);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 3);
            burst_left = $urandom_range(1, 12);
            if (gap > 0)
            begin
                @(negedge clk);
                req_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        req_ch.valid           <= 1'b1;
        req_ch.command         <= cmd;
        req_ch.key_index       <= key;
        req_ch.amplitude_value <= amp;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        sb.note_request(cmd, key, amp);
        if (cmd == CMD_SET)
        begin
            set_count++;
        end
        else
        begin
            gen_count++;
        end
        burst_left--;
    endtask

    // Hold off new requests until every expected sample has come back.
    task wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        sb.set_register(idx, value);
    endtask

    task release_cfg();
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task apply_settings(logic [31:0] keys, logic [31:0] base, logic [31:0] ratio,
                        logic [31:0] coef, logic [31:0] gain);
        wait_drained();
        write_register(CFG_NUM_KEYS, keys);
        write_register(CFG_BASE_STEP, base);
        write_register(CFG_KEY_RATIO, ratio);
        write_register(CFG_SMOOTH_COEF, coef);
        write_register(CFG_OUT_GAIN, gain);
        release_cfg();
        settings_count++;
    endtask

    task run_directed();
        push_request(CMD_SET, 6'd0, AMP_ONE);
        push_request(CMD_SET, 6'd63, 16'hFFFF);
        push_request(CMD_SET, 6'd1, 16'd0);
        push_request(CMD_SET, 6'd2, 16'h8001);
        push_request(CMD_SET, 6'd42, 16'h7FFF);
        repeat (3) push_request(CMD_GEN, 6'd0, 16'd0);
        apply_settings(32'd1, 32'h8000_0000, 32'h4000_0000, 32'hFFFF, 32'hFFFF);
        repeat (3) push_request(CMD_GEN, 6'h3F, 16'hFFFF);
        apply_settings(32'd0, 32'h1234_5678, 32'hFFFF_FFFF, 32'hFFFF, 32'hFFFF);
        push_request(CMD_GEN, 6'd0, 16'd0);
        apply_settings(32'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
        push_request(CMD_GEN, 6'd0, 16'd0);
        apply_settings(32'd64, 32'd26843546, 32'h4400_0000, 32'd40000, 32'd300);
        push_request(CMD_GEN, 6'd0, 16'd0);
        // Writes to indexes past the register list must leave every setting untouched.
        wait_drained();
        for (int i = int'(CFG_OUT_GAIN) + 1; i < (1 << CFG_IDX_W); i++)
        begin
            write_register(CFG_IDX_W'(i), 32'hFFFF_FFFF);
        end
        release_cfg();
        push_request(CMD_SET, 6'd5, 16'h8000);
        push_request(CMD_GEN, 6'd0, 16'd0);
        push_request(CMD_GEN, 6'd0, 16'd0);
    endtask

    task run_random_phase(int phase_no);
        int          pick;
        int          top_key;
        logic [31:0] keys;
        logic [31:0] gain;
        case (phase_no)
            0: apply_settings(32'd64, $urandom(), $urandom_range(32'h4000_0000, 32'hFFFF_FFFF),
                              32'hFFFF, 32'hFFFF);
            1: apply_settings(32'd1, 32'd0, 32'h4000_0000, 32'd0, 32'd0);
            2: apply_settings(32'd127, 32'h8000_0000, 32'hFFFF_FFFF,
                              $urandom_range(0, 65535), $urandom_range(0, 65535));
            default:
            begin
                keys = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
                gain = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) :
                                                     $urandom_range(0, 1024);
                apply_settings(keys, $urandom(), $urandom_range(32'h4000_0000, 32'hFFFF_FFFF),
                               $urandom_range(0, 65535), gain);
            end
        endcase
        top_key = (sb.num_keys == 0) ? 0 :
                  ((sb.num_keys > BANK_KEYS) ? BANK_KEYS - 1 : int'(sb.num_keys) - 1);
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                push_request(CMD_GEN, 6'($urandom()), 16'($urandom()));
            end
            else if (pick < 85)
            begin
                push_request(CMD_SET, 6'($urandom_range(0, top_key)),
                             16'($urandom_range(0, 32768)));
            end
            else
            begin
                push_request(CMD_SET, 6'($urandom()), 16'($urandom()));
            end
        end
    endtask

    initial
    begin
        int mode;
        int mode_left;
        int stall_left;
        rsp_ch.ready <= 1'b0;
        mode_left  = 0;
        stall_left = 0;
        mode       = 0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (mode)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        rsp_ch.ready <= 1'b0;
                    end
                    else if ($urandom_range(0, 15) == 0)
                    begin
                        stall_left = $urandom_range(1, 40);
                        rsp_ch.ready <= 1'b0;
                    end
                    else
                    begin
                        rsp_ch.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            sb.check_sample(rsp_ch.sample, rsp_ch.saturated);
        end
    end

    initial
    begin
        rst_n                  <= 1'b0;
        req_ch.valid           <= 1'b0;
        req_ch.command         <= CMD_SET;
        req_ch.key_index       <= '0;
        req_ch.amplitude_value <= '0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.index           <= CFG_NUM_KEYS;
        cfg_ch.data            <= '0;
        sb             = new();
        burst_left     = 0;
        set_count      = 0;
        gen_count      = 0;
        settings_count = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            run_random_phase(p);
        end

        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d set and %0d generate requests across %0d register settings.",
                 set_count, gen_count, settings_count + 1);
        $display("Compared %0d samples, %0d of them clamped; %0d mismatches.",
                 sb.samples_checked, sb.clamped_seen, sb.failures);
        if (sb.failures == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
